/* sv/hdf_pkg.sv */
`default_nettype none

package hdf_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned IDX_W     = 6;
	localparam int unsigned CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_MODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_ADDRESS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_ADDRESS = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic accept;   // input request taken this cycle
		logic rd_en;    // read frame store at the readout index
		logic advance;  // output request taken this cycle
	} hdf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic close;    // the byte on the input closes a frame
		logic last;     // the readout index is the final byte
	} hdf_stat_t;

endpackage

`default_nettype wire

/* sv/hdf_if.sv */
`default_nettype none

interface hdf_rx_if import hdf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hdf_frame_if import hdf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic [IDX_W-1:0]  byte_index;
	logic              frame_last;

	modport source (output valid, output frame_byte, output byte_index, output frame_last,
		input ready);
	modport sink   (input valid, input frame_byte, input byte_index, input frame_last,
		output ready);
endinterface

interface hdf_cfg_if import hdf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/hdf_ram.sv */
`default_nettype none

module hdf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/hdf_ctrl.sv */
`default_nettype none

module hdf_ctrl import hdf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      rx_valid,
	output logic           rx_ready,
	output logic           frame_valid,
	input  wire logic      frame_ready,
	input  wire hdf_stat_t stat,
	output hdf_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_SHOW = 3'b100
	} hdf_state_t;

	hdf_state_t state_q, state_d;

	always_comb begin
		rx_ready    = (state_q == ST_IDLE);
		frame_valid = (state_q == ST_SHOW);
		cmd.accept  = rx_valid && rx_ready;
		cmd.rd_en   = (state_q == ST_READ);
		cmd.advance = frame_valid && frame_ready;
		state_d     = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && stat.close) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				if (frame_ready) begin
					state_d = stat.last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* sv/hdf_dp.sv */
`default_nettype none

module hdf_dp import hdf_pkg::*; #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	input  wire hdf_cmd_t             cmd,
	output hdf_stat_t                 stat,
	output logic      [BYTE_W-1:0]    frame_byte,
	output logic      [IDX_W-1:0]     byte_index,
	output logic                      frame_last
);

	localparam int unsigned CW = $clog2(MAX_FRAME + 1);
	localparam int unsigned AW = $clog2(MAX_FRAME);

	logic [BYTE_W-1:0] header_q, tail_q, first_q, second_q;
	logic              addr_mode_q;

	logic [CW-1:0]     fill_q, len_q;
	logic [AW-1:0]     rd_idx_q;
	logic [BYTE_W-1:0] hdr0_q, hdr1_q;   // copies of stored bytes 0 and 1

	logic [CW-1:0] head, fill_nxt;
	logic          pre_hdr, at_hdr, hdr_ok, store;

	always_comb begin
		head     = addr_mode_q ? CW'(2) : CW'(1);
		fill_nxt = fill_q + CW'(1);
		pre_hdr  = fill_q < head;
		at_hdr   = fill_q == head;
		hdr_ok   = (hdr0_q == header_q) &&
			(!addr_mode_q || ((hdr1_q == first_q) && (rx_byte == second_q)));
		store    = !at_hdr || hdr_ok;
		stat.close = !pre_hdr && !at_hdr &&
			((rx_byte == tail_q) || (fill_nxt == CW'(MAX_FRAME)));
		stat.last  = (CW'(rd_idx_q) + CW'(1)) == len_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q    <= '0;
			tail_q      <= '0;
			addr_mode_q <= 1'b0;
			first_q     <= '0;
			second_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_BYTE:    header_q    <= cfg_data;
				REG_TAIL_BYTE:      tail_q      <= cfg_data;
				REG_ADDRESS_MODE:   addr_mode_q <= cfg_data[0];
				REG_FIRST_ADDRESS:  first_q     <= cfg_data;
				REG_SECOND_ADDRESS: second_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			len_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (stat.close) begin
					fill_q   <= '0;
					len_q    <= fill_nxt;
					rd_idx_q <= '0;
				end else if (store) begin
					fill_q <= fill_nxt;
				end else begin
					fill_q <= '0;
				end
			end else if (cmd.advance) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && store && (fill_q == CW'(0))) begin
			hdr0_q <= rx_byte;
		end
		if (cmd.accept && store && (fill_q == CW'(1))) begin
			hdr1_q <= rx_byte;
		end
	end

	hdf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_FRAME)
	) u_store (
		.clk   (clk),
		.we    (cmd.accept && store),
		.waddr (fill_q[AW-1:0]),
		.wdata (rx_byte),
		.re    (cmd.rd_en),
		.raddr (rd_idx_q),
		.rdata (frame_byte)
	);

	assign byte_index = IDX_W'(rd_idx_q);
	assign frame_last = stat.last;

endmodule

`default_nettype wire

/* sv/header_tail_packet_deframer_unit.sv */
// Channel  Role    Payload                                 Handshake
// rx       sink    rx_byte[7:0]                            valid/ready
// frame    source  frame_byte[7:0] byte_index[5:0] last    valid/ready
// cfg      sink    index[2:0] data[7:0]                    valid/ready (ready tied high)
//
// A received byte is taken when rx is ready; frame bytes are stored in the frame RAM.
// Readout takes each byte through a RAM read, then a show, and output stalls
// can hold the show.
// rx.ready is low for the whole readout; one request at a time is in flight.
// arst_n clears the controller, fill count and configuration; the RAM is not cleared.
// A stalled output request holds its payload until frame.ready.
`default_nettype none

module header_tail_packet_deframer_unit import hdf_pkg::*; #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hdf_rx_if.sink      rx,
	hdf_frame_if.source frame,
	hdf_cfg_if.sink     cfg
);

	hdf_cmd_t  cmd;
	hdf_stat_t stat;

	// configuration writes go straight into registers, so never back-pressure them
	assign cfg.ready = 1'b1;

	// controller: sequence accept, read and show
	hdf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx.valid),
		.rx_ready    (rx.ready),
		.frame_valid (frame.valid),
		.frame_ready (frame.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	// datapath: header check, fill count, frame store and readout index
	hdf_dp #(
		.MAX_FRAME (MAX_FRAME)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx.rx_byte),
		.cfg_we     (cfg.valid && cfg.ready),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.cmd        (cmd),
		.stat       (stat),
		.frame_byte (frame.frame_byte),
		.byte_index (frame.byte_index),
		.frame_last (frame.frame_last)
	);

	// no input request is taken while a frame byte is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid |-> !rx.ready)
		else $error("input ready while readout active");

	// the final byte of a frame returns the block to reception
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready && frame.frame_last) |=> rx.ready)
		else $error("block not idle after final frame byte");

	// readout steps through consecutive positions
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready && !frame.frame_last) |=> ##1
		(frame.valid && (frame.byte_index == IDX_W'($past(frame.byte_index, 2) + IDX_W'(1)))))
		else $error("frame byte index did not advance by one");

	// a closing input byte starts a readout
	a_close_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && stat.close) |=> cmd.rd_en)
		else $error("closed frame not read out");

endmodule

`default_nettype wire
